@@ hw/rtl/i2r_pkg.sv @@
// Shared types, numeral rule tables and a helper function for the Roman numeral converter.
package i2r_pkg;

    localparam int NUM_RULES = 13;
    localparam int RULE_IDX_W = $clog2(NUM_RULES);
    localparam int VALUE_W = 12;
    localparam int WEIGHT_W = 10;
    localparam int CHAR_W = 8;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

    typedef logic [RULE_IDX_W-1:0] rule_idx_t;

    localparam logic [WEIGHT_W-1:0] RULE_WEIGHT [NUM_RULES] = '{
        10'd1000, 10'd900, 10'd500, 10'd400, 10'd100, 10'd90, 10'd50,
        10'd40, 10'd10, 10'd9, 10'd5, 10'd4, 10'd1
    };

    localparam logic [CHAR_W-1:0] RULE_FIRST [NUM_RULES] = '{
        "M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"
    };

    localparam logic [CHAR_W-1:0] RULE_SECOND [NUM_RULES] = '{
        CHAR_NUL, "M", CHAR_NUL, "D", CHAR_NUL, "C", CHAR_NUL, "L", CHAR_NUL,
        "X", CHAR_NUL, "V", CHAR_NUL
    };

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed
    {
        logic load;
        logic step;
        logic term;
    } i2r_cmd_t;

    typedef struct packed
    {
        logic done;
        logic out_free;
    } i2r_status_t;

    // Pick the largest rule weight that does not exceed the remainder.
    function automatic rule_idx_t pick_rule(input logic [VALUE_W-1:0] rem);
        rule_idx_t idx;
        idx = rule_idx_t'(NUM_RULES - 1);
        for (int i = NUM_RULES - 1; i >= 0; i--)
        begin
            if (rem >= {{(VALUE_W-WEIGHT_W){1'b0}}, RULE_WEIGHT[i]})
            begin
                idx = rule_idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ hw/rtl/i2r_ctrl.sv @@
// Controller state machine sequencing load, character steps and terminator.
module i2r_ctrl
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  i2r_status_t status,
    output i2r_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    if (status.done)
                    begin
                        cmd.term   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/i2r_datapath.sv @@
// Datapath: remainder register, rule selection, pending second character and output register.
module i2r_datapath
    import i2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  i2r_cmd_t           cmd,
    output i2r_status_t        status,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CHAR_W-1:0]  out_char,
    output logic               out_last
);

    logic [VALUE_W-1:0] remaining_reg;
    logic [VALUE_W-1:0] remaining_next;
    logic [CHAR_W-1:0]  pend_char_reg;
    logic [CHAR_W-1:0]  pend_char_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [CHAR_W-1:0]  out_char_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rule_idx_t          rule_idx;
    logic [VALUE_W-1:0] clamped;

    assign rule_idx = pick_rule(remaining_reg);
    assign clamped  = (value > MAX_VALUE) ? MAX_VALUE : value;

    always_comb
    begin
        remaining_next  = remaining_reg;
        pend_char_next  = pend_char_reg;
        pend_valid_next = pend_valid_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (cmd.load)
        begin
            remaining_next  = clamped;
            pend_valid_next = 1'b0;
        end
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            if (pend_valid_reg)
            begin
                out_char_next   = pend_char_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_char_next   = RULE_FIRST[rule_idx];
                pend_char_next  = RULE_SECOND[rule_idx];
                pend_valid_next = (RULE_SECOND[rule_idx] != CHAR_NUL);
                remaining_next  = remaining_reg
                                - {{(VALUE_W-WEIGHT_W){1'b0}}, RULE_WEIGHT[rule_idx]};
            end
        end
        if (cmd.term)
        begin
            out_valid_next = 1'b1;
            out_char_next  = CHAR_NUL;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        pend_char_reg <= pend_char_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    assign status.done     = (remaining_reg == '0) && !pend_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_char        = out_char_reg;
    assign out_last        = out_last_reg;

endmodule

@@ hw/rtl/integer_to_roman_numeral.sv @@
// An accepted input beat is registered as the remainder; the first step, if any,
// then moves the first character into the output register. Output runs one character per cycle
//   from the single output register unless m_tready stalls it, ending with a NUL terminator.
// The next input beat is taken while the terminator still waits at the output.
// Reset (rst_n low, asynchronous): controller idle, output and pending char empty.
// Top level of the integer to Roman numeral converter.
module integer_to_roman_numeral
    import i2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic        m_tlast
);

    i2r_cmd_t    cmd;
    i2r_status_t status;

    i2r_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2r_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (s_tdata[VALUE_W-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

    a_term_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == CHAR_NUL)
        else $error("terminator beat carries a nonzero character");

    a_char_not_nul: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata != CHAR_NUL)
        else $error("numeral beat carries a NUL character");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again before the run finished");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.step, cmd.term}) <= 1)
        else $error("controller issued more than one command");

endmodule
